### design/assert_macros.svh
// assertion macros for the deque rtl, used by ladq_dp
// clocked on clk_i and disabled while rst_ni is low in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LADQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define LADQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LADQ_ASSERT(label, cond, msg)
`define LADQ_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

### design/ladq_pkg.sv
// shared types, codes and constants for the linear array deque
// used by ladq_ctrl, ladq_dp and linear_array_deque_core
package ladq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_W         = $clog2(MAX_RESULTS);
  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_DUMP       = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    first;
    logic    wr_front;
    logic    wr_back;
    logic    rd_front;
    logic    rd_back;
    logic    dump_start;
    logic    dump_step;
    logic    load_direct;
    status_e direct_st;
    logic    load_read;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic head_zero;
    logic tail_end;
    logic rd_pend;
    logic rd_last;
    logic more;
    logic out_free;
  } sts_t;

endpackage

### design/ladq_ctrl.sv
// request sequencer for the linear array deque
// depends on ladq_pkg for codes and the command and status structs
module ladq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ladq_pkg::FUNC_W-1:0] func_i,
  input  ladq_pkg::sts_t              sts_i,
  output ladq_pkg::cmd_t              cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_stall_o = !((state_q == S_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (ladq_pkg::func_e'(func_i)) inside
            ladq_pkg::FUNC_PUSH_FRONT: begin
              cmd_o.load_direct = 1'b1;
              if (sts_i.empty) begin
                cmd_o.first = 1'b1;
              end else if (!sts_i.head_zero) begin
                cmd_o.wr_front = 1'b1;
              end else begin
                cmd_o.direct_st = ladq_pkg::ST_OVERFLOW;
              end
            end
            ladq_pkg::FUNC_PUSH_BACK: begin
              cmd_o.load_direct = 1'b1;
              if (sts_i.empty) begin
                cmd_o.first = 1'b1;
              end else if (!sts_i.tail_end) begin
                cmd_o.wr_back = 1'b1;
              end else begin
                cmd_o.direct_st = ladq_pkg::ST_OVERFLOW;
              end
            end
            ladq_pkg::FUNC_POP_FRONT, ladq_pkg::FUNC_POP_BACK: begin
              if (sts_i.empty) begin
                cmd_o.load_direct = 1'b1;
                cmd_o.direct_st   = ladq_pkg::ST_EMPTY;
              end else begin
                cmd_o.rd_front = (func_i == ladq_pkg::FUNC_POP_FRONT);
                cmd_o.rd_back  = (func_i == ladq_pkg::FUNC_POP_BACK);
                state_d        = S_READ;
              end
            end
            ladq_pkg::FUNC_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.load_direct = 1'b1;
                cmd_o.direct_st   = ladq_pkg::ST_EMPTY;
              end else begin
                cmd_o.dump_start = 1'b1;
                state_d          = S_READ;
              end
            end
            default: begin
              // unused codes: no change, no result
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.load_read = sts_i.rd_pend && sts_i.out_free;
        cmd_o.dump_step = sts_i.more && (!sts_i.rd_pend || cmd_o.load_read);
        if (cmd_o.load_read && sts_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/ladq_dp.sv
// element store, end indices, read pipeline and result register of the deque
// depends on ladq_pkg and assert_macros.svh
`include "assert_macros.svh"

module ladq_dp #(
  parameter int Depth = ladq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [ladq_pkg::DATA_W-1:0]   push_value_i,
  input  ladq_pkg::cmd_t                       cmd_i,
  output ladq_pkg::sts_t                       sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ladq_pkg::DATA_W-1:0]   data_value_o,
  output logic        [ladq_pkg::STATUS_W-1:0] status_o,
  output logic                                 last_o
);

  localparam int IdxW = $clog2(Depth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [ladq_pkg::DATA_W-1:0] mem_q [Depth];
  logic [ladq_pkg::DATA_W-1:0] rd_data_q;

  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [ladq_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic empty_q, empty_d;
  logic rd_pend_q, rd_pend_d, rd_last_q, rd_last_d, more_q, more_d;

  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic            same_end;
  logic            step_last;

  logic                                 out_valid_q;
  logic        [ladq_pkg::DATA_W-1:0]   out_data_q;
  logic        [ladq_pkg::STATUS_W-1:0] out_st_q;
  logic                                 out_last_q;
  logic                                 out_free;

  assign same_end  = (head_q == tail_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_last = (ptr_q == tail_q) ||
                     (cnt_q == ladq_pkg::CNT_W'(ladq_pkg::MAX_RESULTS - 1));

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    rd_last_d = rd_last_q;
    more_d    = more_q;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_en     = 1'b0;
    rd_addr   = head_q;
    if (cmd_i.first) begin
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b0;
      wr_en   = 1'b1;
      wr_addr = '0;
    end
    if (cmd_i.wr_front) begin
      head_d  = head_q - 1'b1;
      wr_en   = 1'b1;
      wr_addr = head_q - 1'b1;
    end
    if (cmd_i.wr_back) begin
      tail_d  = tail_q + 1'b1;
      wr_en   = 1'b1;
      wr_addr = tail_q + 1'b1;
    end
    if (cmd_i.rd_front || cmd_i.rd_back) begin
      rd_en     = 1'b1;
      rd_addr   = cmd_i.rd_front ? head_q : tail_q;
      rd_last_d = 1'b1;
      more_d    = 1'b0;
      if (same_end) begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end else if (cmd_i.rd_front) begin
        head_d = head_q + 1'b1;
      end else begin
        tail_d = tail_q - 1'b1;
      end
    end
    if (cmd_i.dump_start) begin
      rd_en     = 1'b1;
      rd_addr   = head_q;
      ptr_d     = head_q + 1'b1;
      cnt_d     = ladq_pkg::CNT_W'(1);
      rd_last_d = same_end || (ladq_pkg::MAX_RESULTS == 1);
      more_d    = !rd_last_d;
    end
    if (cmd_i.dump_step) begin
      rd_en     = 1'b1;
      rd_addr   = ptr_q;
      ptr_d     = ptr_q + 1'b1;
      cnt_d     = cnt_q + 1'b1;
      rd_last_d = step_last;
      more_d    = !step_last;
    end
    if (rd_en) begin
      rd_pend_d = 1'b1;
    end else if (cmd_i.load_read) begin
      rd_pend_d = 1'b0;
    end else begin
      rd_pend_d = rd_pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      empty_q   <= 1'b1;
      ptr_q     <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
      more_q    <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      empty_q   <= empty_d;
      ptr_q     <= ptr_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      rd_last_q <= rd_last_d;
      more_q    <= more_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_direct || cmd_i.load_read) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_direct) begin
      out_data_q <= (cmd_i.direct_st == ladq_pkg::ST_OK) ? push_value_i : '0;
      out_st_q   <= cmd_i.direct_st;
      out_last_q <= 1'b1;
    end else if (cmd_i.load_read) begin
      out_data_q <= rd_data_q;
      out_st_q   <= ladq_pkg::ST_OK;
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_value_o = out_data_q;
  assign status_o     = out_st_q;
  assign last_o       = out_last_q;

  assign sts_o.empty     = empty_q;
  assign sts_o.head_zero = (head_q == '0);
  assign sts_o.tail_end  = (tail_q == LastIdx);
  assign sts_o.rd_pend   = rd_pend_q;
  assign sts_o.rd_last   = rd_last_q;
  assign sts_o.more      = more_q;
  assign sts_o.out_free  = out_free;

  `LADQ_ASSERT(a_empty_idx, !empty_q || (head_q == '0 && tail_q == '0), "empty with indices set")
  `LADQ_ASSERT(a_order, empty_q || (head_q <= tail_q), "head past tail")
  `LADQ_ASSERT_IMP(a_load_pend, cmd_i.load_read, rd_pend_q, "result taken with no read pending")
  `LADQ_ASSERT_IMP(a_rw_excl, rd_en, !wr_en, "store read and written together")
  `LADQ_ASSERT_IMP(a_no_clobber, out_valid_q && out_stall_i, !(cmd_i.load_direct || cmd_i.load_read), "held result overwritten")

endmodule

### design/linear_array_deque_core.sv
// top level of the linear array deque: sequencer plus datapath
// depends on ladq_pkg, ladq_ctrl and ladq_dp
//
// Double-ended queue of signed 32-bit elements in a non-circular store of Depth slots.
// A push, or any request that fails (overflow, empty queue), gives its single result
// in the cycle after it is taken. A pop passes through the store's one registered read
// port and then the result register, and a stalled output can hold it in between. A dump
// of n elements streams through that read port, one element per cycle while the output
// is not stalled, at most 16 elements. Requests are taken only once the previous one
// has issued all its results, and a waiting result not being taken holds the input stalled.
module linear_array_deque_core #(
  parameter int Depth = ladq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [ladq_pkg::FUNC_W-1:0]   func_i,
  input  logic signed [ladq_pkg::DATA_W-1:0]   push_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ladq_pkg::DATA_W-1:0]   data_value_o,
  output logic        [ladq_pkg::STATUS_W-1:0] status_o,
  output logic                                 last_o
);

  ladq_pkg::cmd_t cmd;
  ladq_pkg::sts_t sts;

  ladq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ladq_dp #(
    .Depth (Depth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_value_i (push_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_value_o (data_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

### tb/sv/tb_linear_array_deque_core.sv
// self-checking testbench for linear_array_deque_core: directed and random deque requests
// with a cycle-free deque predictor, idling on both sides and a drain pause
// depends on ladq_pkg and linear_array_deque_core
module tb_linear_array_deque_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int SLOTS          = ladq_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_TARGET  = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int FW             = ladq_pkg::FUNC_W;
  localparam int DW             = ladq_pkg::DATA_W;

  localparam logic [FW-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [FW-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FW-1:0] FUNC_SPARE_7 = 3'd7;

  typedef struct {
    logic [FW-1:0]        func;
    logic signed [DW-1:0] value;
    bit                   wait_drain;
  } deque_request_t;

  typedef struct {
    logic signed [DW-1:0] data;
    ladq_pkg::status_e    status;
    logic                 last;
  } deque_result_t;

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [FW-1:0]                   func_i       = '0;
  logic signed [DW-1:0]            push_value_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic signed [DW-1:0]            data_value_o;
  logic [ladq_pkg::STATUS_W-1:0]   status_o;
  logic                            last_o;

  deque_request_t pending_requests[$];
  deque_result_t  expected_results[$];

  logic signed [DW-1:0] dq_store [SLOTS];
  int                   dq_head  = 0;
  int                   dq_tail  = 0;
  bit                   dq_empty = 1'b1;

  int error_count    = 0;
  int total_requests = 1;
  int counted_ops    = 0;
  int sent_count     = 0;
  int idle_phase     = 0;
  int quiet_cycles   = 0;
  bit results_busy   = 1'b0;
  bit req_taken;
  int tx_idle_pct;

  linear_array_deque_core #(
    .Depth(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_value_o (data_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_deque_op(input logic [FW-1:0] func,
                                           input logic signed [DW-1:0] value);
    logic signed [DW-1:0] popped;
    int i;
    int n;
    case (func)
      ladq_pkg::FUNC_PUSH_FRONT, ladq_pkg::FUNC_PUSH_BACK: begin
        if (dq_empty) begin
          dq_head = 0;
          dq_tail = 0;
          dq_store[0] = value;
          dq_empty = 1'b0;
          expected_results.push_back('{value, ladq_pkg::ST_OK, 1'b1});
        end else if (func == ladq_pkg::FUNC_PUSH_FRONT && dq_head != 0) begin
          dq_head--;
          dq_store[dq_head] = value;
          expected_results.push_back('{value, ladq_pkg::ST_OK, 1'b1});
        end else if (func == ladq_pkg::FUNC_PUSH_BACK && dq_tail != SLOTS - 1) begin
          dq_tail++;
          dq_store[dq_tail] = value;
          expected_results.push_back('{value, ladq_pkg::ST_OK, 1'b1});
        end else begin
          expected_results.push_back('{'0, ladq_pkg::ST_OVERFLOW, 1'b1});
        end
      end
      ladq_pkg::FUNC_POP_FRONT, ladq_pkg::FUNC_POP_BACK: begin
        if (dq_empty) begin
          expected_results.push_back('{'0, ladq_pkg::ST_EMPTY, 1'b1});
        end else begin
          popped = (func == ladq_pkg::FUNC_POP_FRONT) ? dq_store[dq_head] : dq_store[dq_tail];
          if (dq_head == dq_tail) begin
            dq_head = 0;
            dq_tail = 0;
            dq_empty = 1'b1;
          end else if (func == ladq_pkg::FUNC_POP_FRONT) begin
            dq_head++;
          end else begin
            dq_tail--;
          end
          expected_results.push_back('{popped, ladq_pkg::ST_OK, 1'b1});
        end
      end
      ladq_pkg::FUNC_DUMP: begin
        if (dq_empty) begin
          expected_results.push_back('{'0, ladq_pkg::ST_EMPTY, 1'b1});
        end else begin
          n = 0;
          for (i = dq_head; i <= dq_tail && n < ladq_pkg::MAX_RESULTS; i++) begin
            expected_results.push_back('{dq_store[i], ladq_pkg::ST_OK,
                                         (i == dq_tail) || (n == ladq_pkg::MAX_RESULTS - 1)});
            n++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return -1;
      2:       return 32'sh7fff_ffff;
      default: return 32'sh8000_0000;
    endcase
  endfunction

  task automatic queue_request(input logic [FW-1:0] func,
                               input logic signed [DW-1:0] value,
                               input bit wait_drain = 1'b0);
    pending_requests.push_back('{func, value, wait_drain});
    if (func <= ladq_pkg::FUNC_DUMP) counted_ops++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      func_i       <= '0;
      push_value_i <= '0;
    end else begin
      req_taken = in_valid_i && !in_stall_o;
      if (req_taken) begin
        pending_requests.delete(0);
        sent_count++;
        idle_phase <= (sent_count * 3 / total_requests > 2) ? 2 : sent_count * 3 / total_requests;
      end
      tx_idle_pct = (idle_phase == 0) ? 29 : (idle_phase == 1) ? 59 : 0;
      if (in_valid_i && !req_taken) begin
        // stalled: hold the request
      end else if (pending_requests.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if ((pending_requests[0].wait_drain && (results_busy || req_taken)) ||
                   $urandom_range(0, 99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i   <= 1'b1;
        func_i       <= pending_requests[0].func;
        push_value_i <= pending_requests[0].value;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      results_busy <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result data %0d status %0d last %0b",
                                    data_value_o, status_o, last_o));
        end else begin
          want = expected_results.pop_front();
          if (data_value_o !== want.data)
            report_mismatch($sformatf("data_value got %0d want %0d", data_value_o, want.data));
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (last_o !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", last_o, want.last));
        end
      end
      if (in_valid_i && !in_stall_o) predict_deque_op(func_i, push_value_i);
      results_busy <= expected_results.size() != 0;
      out_stall_i  <= $urandom_range(0, 99) < ((idle_phase == 0) ? 59 :
                                               (idle_phase == 1) ? 29 : 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int n;
    int k;
    bit filled;
    logic [FW-1:0] op;

    // empty queue, spare codes, both ends, overflow at the front
    queue_request(ladq_pkg::FUNC_POP_FRONT, pick_value());
    queue_request(ladq_pkg::FUNC_POP_BACK, pick_value());
    queue_request(ladq_pkg::FUNC_DUMP, pick_value());
    queue_request(FUNC_SPARE_5, pick_value());
    queue_request(FUNC_SPARE_6, pick_value());
    queue_request(FUNC_SPARE_7, pick_value());
    queue_request(ladq_pkg::FUNC_PUSH_BACK, 32'sh7fff_ffff);
    queue_request(ladq_pkg::FUNC_PUSH_FRONT, 32'sh1234_5678);
    queue_request(ladq_pkg::FUNC_PUSH_BACK, 32'sh8000_0000);
    queue_request(ladq_pkg::FUNC_DUMP, '0);
    queue_request(ladq_pkg::FUNC_POP_FRONT, '0);
    queue_request(ladq_pkg::FUNC_PUSH_FRONT, -1);
    queue_request(ladq_pkg::FUNC_PUSH_FRONT, '0);
    queue_request(ladq_pkg::FUNC_DUMP, '0);
    queue_request(ladq_pkg::FUNC_POP_BACK, '0);
    queue_request(ladq_pkg::FUNC_POP_FRONT, '0);
    queue_request(ladq_pkg::FUNC_PUSH_FRONT, 32'sh5555_aaaa);
    queue_request(ladq_pkg::FUNC_POP_BACK, '0);
    queue_request(ladq_pkg::FUNC_PUSH_BACK, 32'sh2aaa_5555, 1'b1);
    queue_request(ladq_pkg::FUNC_POP_FRONT, '0);

    // first random episode always fills to the back end
    kind   = 0;
    filled = 1'b0;
    while (counted_ops < RANDOM_TARGET) begin
      case (kind)
        0, 1, 2: begin
          n = filled ? $urandom_range(4, SLOTS + 1) : SLOTS + 1;
          filled = 1'b1;
          for (k = 0; k < n; k++) queue_request(ladq_pkg::FUNC_PUSH_BACK, pick_value());
          queue_request(ladq_pkg::FUNC_DUMP, pick_value());
        end
        3, 4: begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++)
            queue_request($urandom_range(0, 1) ? ladq_pkg::FUNC_POP_FRONT :
                                                 ladq_pkg::FUNC_POP_BACK, pick_value());
        end
        5: begin
          op = FW'($urandom_range(0, 7));
          queue_request(op, pick_value(), $urandom_range(0, 9) == 0);
        end
        default: begin
          for (k = 0; k < 6; k++) begin
            op = FW'($urandom_range(0, 4));
            queue_request(op, pick_value());
          end
        end
      endcase
      kind = $urandom_range(0, 9);
    end
    total_requests = pending_requests.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_requests.size() != 0 || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
